// ----- rtl/line_substring_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// line_substring_filter_top_defines
// assertion macros used by the line filter rtl (lsf_line_ctl)
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_TOP_DEFINES_SVH
`define LINE_SUBSTRING_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// concurrent check, disabled while reset is asserted
`define LSF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also runs during reset
`define LSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSF_ASSERT(label, clk, rst_n, prop, msg)
`define LSF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg
// shared types, constants and helpers of the line substring filter
// ----------------------------------------------------------------------------
package lsf_pkg;

  // fixed field widths
  localparam int unsigned PAT_W       = 64;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned PAT_IDX_W   = 4;
  localparam int unsigned PAT_LEN_W   = 5;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned LSF_MAX_PATTERN = 16;

  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_IGNORE_CASE    = 3'd3,
    REG_INVERT_MATCH   = 3'd4,
    REG_REPORT_MODE    = 3'd5
  } lsf_reg_e;

  // report modes; the remaining code behaves as count only
  typedef enum logic [1:0] {
    MODE_VERDICT  = 2'd0,
    MODE_NUMBERED = 2'd1,
    MODE_COUNT    = 2'd2
  } lsf_mode_e;

  // result kinds
  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_COUNT   = 1'b1
  } lsf_kind_e;

  typedef struct packed {
    logic [PAT_W-1:0]     pattern_low;
    logic [PAT_W-1:0]     pattern_high;
    logic [PAT_LEN_W-1:0] pattern_length;
    logic                 ignore_case;
    logic                 invert_match;
    logic [1:0]           report_mode;
  } lsf_cfg_t;

  // decoded meaning of one accepted input transfer
  typedef struct packed {
    logic push;     // ordinary text byte
    logic newline;  // line terminator
    logic eos;      // end of stream
  } lsf_step_t;

  typedef struct packed {
    logic             kind;
    logic [CNT_W-1:0] line_number;
    logic             selected;
    logic [CNT_W-1:0] match_count;
    logic             last_of_run;
  } lsf_res_t;

  // ascii upper to lower case when folding is enabled
  function automatic logic [7:0] lsf_fold(input logic [7:0] b, input logic en);
    if (en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

endpackage

// ----- rtl/lsf_in_if.sv -----
// ----------------------------------------------------------------------------
// lsf_in_if
// text byte channel: valid/ready plus one byte or an end of stream mark
// ----------------------------------------------------------------------------
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_stream;

  modport source (output valid, output ch, output end_of_stream, input ready);
  modport sink   (input valid, input ch, input end_of_stream, output ready);
endinterface

// ----- rtl/lsf_out_if.sv -----
// ----------------------------------------------------------------------------
// lsf_out_if
// result channel: line verdicts and the final count of selected lines
// ----------------------------------------------------------------------------
interface lsf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] line_number;
  logic        selected;
  logic [31:0] match_count;
  logic        last_of_run;

  modport source (output valid, output kind, output line_number, output selected,
                  output match_count, output last_of_run, input ready);
  modport sink   (input valid, input kind, input line_number, input selected,
                  input match_count, input last_of_run, output ready);
endinterface

// ----- rtl/lsf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lsf_cfg_regs
// configuration register file written through a plain write port
// ----------------------------------------------------------------------------
module lsf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsf_pkg::PAT_W-1:0]     cfg_data_i,
  output lsf_pkg::lsf_cfg_t             cfg_o
);
  import lsf_pkg::*;

  lsf_cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LOW:    cfg_d.pattern_low    = cfg_data_i;
        REG_PATTERN_HIGH:   cfg_d.pattern_high   = cfg_data_i;
        REG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_data_i[PAT_LEN_W-1:0];
        REG_IGNORE_CASE:    cfg_d.ignore_case    = cfg_data_i[0];
        REG_INVERT_MATCH:   cfg_d.invert_match   = cfg_data_i[0];
        REG_REPORT_MODE:    cfg_d.report_mode    = cfg_data_i[1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/lsf_matcher.sv -----
// ----------------------------------------------------------------------------
// lsf_matcher
// sliding byte window of the current line, compared with the whole pattern
// ----------------------------------------------------------------------------
module lsf_matcher #(
  parameter int unsigned MAX_PATTERN = lsf_pkg::LSF_MAX_PATTERN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsf_pkg::lsf_cfg_t  cfg_i,
  input  lsf_pkg::lsf_step_t step_i,
  input  logic [7:0]         ch_i,
  output logic               hit_o
);
  import lsf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

  logic [7:0]           win_q   [MAX_PATTERN];
  logic [7:0]           win_new [MAX_PATTERN];
  logic [7:0]           pat_bytes [PAT_BYTES];
  logic [2*PAT_W-1:0]   pat_all;
  logic [CW-1:0]        chars_q, chars_d, chars_inc;
  logic [PAT_LEN_W-1:0] len_eff;
  logic [MAX_PATTERN-1:0] pos_ok;

  // window as it stands after the incoming byte
  always_comb begin
    win_new[0] = ch_i;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  // pattern bytes from the two pattern words
  assign pat_all = {cfg_i.pattern_high, cfg_i.pattern_low};

  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      pat_bytes[k] = pat_all[k*8 +: 8];
    end
  end

  // effective pattern length, clamped to the window depth
  assign len_eff = (cfg_i.pattern_length > PAT_LEN_W'(MAX_PATTERN)) ?
                   PAT_LEN_W'(MAX_PATTERN) : cfg_i.pattern_length;

  assign chars_inc = (chars_q < CW'(MAX_PATTERN)) ? CW'(chars_q + CW'(1)) : chars_q;

  // window entry i lines up with pattern byte len-1-i
  always_comb begin
    logic [PAT_LEN_W-1:0] pidx;
    logic [7:0]           pb;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx = PAT_LEN_W'(len_eff - PAT_LEN_W'(i) - PAT_LEN_W'(1));
      pb   = pat_bytes[pidx[PAT_IDX_W-1:0]];
      pos_ok[i] = (PAT_LEN_W'(i) >= len_eff) ||
                  (lsf_fold(win_new[i], cfg_i.ignore_case) ==
                   lsf_fold(pb, cfg_i.ignore_case));
    end
  end

  assign hit_o = (len_eff != '0) && (PAT_LEN_W'(chars_inc) >= len_eff) && (&pos_ok);

  // byte count of the current line, saturating at MAX_PATTERN
  always_comb begin
    chars_d = chars_q;
    if (step_i.push) begin
      chars_d = chars_inc;
    end else if (step_i.newline || step_i.eos) begin
      chars_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
    end else begin
      chars_q <= chars_d;
    end
  end

  // window shift; entries past the byte count are never compared
  always_ff @(posedge clk_i) begin
    if (step_i.push) begin
      win_q <= win_new;
    end
  end

endmodule

// ----- rtl/lsf_line_ctl.sv -----
// ----------------------------------------------------------------------------
// lsf_line_ctl
// line state, saturating counters and the result register
// ----------------------------------------------------------------------------
`include "line_substring_filter_top_defines.svh"

module lsf_line_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsf_pkg::lsf_cfg_t  cfg_i,
  input  lsf_pkg::lsf_step_t step_i,
  input  logic               hit_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output lsf_pkg::lsf_res_t  res_o
);
  import lsf_pkg::*;

  logic             line_hit_q, line_hit_d;
  logic             line_open_q, line_open_d;
  logic [CNT_W-1:0] line_cnt_q, line_cnt_d;
  logic [CNT_W-1:0] sel_cnt_q, sel_cnt_d;
  logic [CNT_W-1:0] line_fin, sel_fin, line_after, sel_after;
  logic             finish, sel, count_only, emit_verdict, emit_count;
  logic             res_valid_q, res_valid_d;
  lsf_res_t         res_q, res_d;

  // line judgement and counter updates
  always_comb begin
    finish     = step_i.newline || (step_i.eos && line_open_q);
    sel        = line_hit_q ^ cfg_i.invert_match;
    count_only = !((cfg_i.report_mode == MODE_VERDICT) ||
                   (cfg_i.report_mode == MODE_NUMBERED));
    line_fin   = (line_cnt_q == '1) ? line_cnt_q : line_cnt_q + CNT_W'(1);
    sel_fin    = (sel && (sel_cnt_q != '1)) ? sel_cnt_q + CNT_W'(1) : sel_cnt_q;
    line_after = finish ? line_fin : line_cnt_q;
    sel_after  = finish ? sel_fin : sel_cnt_q;

    line_hit_d  = line_hit_q;
    line_open_d = line_open_q;
    line_cnt_d  = line_cnt_q;
    sel_cnt_d   = sel_cnt_q;
    if (step_i.push) begin
      line_hit_d  = line_hit_q | hit_i;
      line_open_d = 1'b1;
    end else if (step_i.newline) begin
      line_hit_d  = 1'b0;
      line_open_d = 1'b0;
      line_cnt_d  = line_after;
      sel_cnt_d   = sel_after;
    end else if (step_i.eos) begin
      line_hit_d  = 1'b0;
      line_open_d = 1'b0;
      line_cnt_d  = '0;
      sel_cnt_d   = '0;
    end

    emit_verdict = finish && !count_only;
    emit_count   = step_i.eos && count_only;
  end

  // result payload; every input causes at most one result
  always_comb begin
    res_d             = res_q;
    res_d.last_of_run = 1'b1;
    if (emit_count) begin
      res_d.kind        = KIND_COUNT;
      res_d.line_number = line_after;
      res_d.selected    = 1'b0;
      res_d.match_count = sel_after;
    end else if (emit_verdict) begin
      res_d.kind        = KIND_VERDICT;
      res_d.line_number = (cfg_i.report_mode == MODE_NUMBERED) ? line_after : '0;
      res_d.selected    = sel;
      res_d.match_count = sel_after;
    end
  end

  // result valid: load on a new result, drop on a transfer
  always_comb begin
    if (emit_verdict || emit_count) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_hit_q  <= 1'b0;
      line_open_q <= 1'b0;
      line_cnt_q  <= '0;
      sel_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      line_hit_q  <= line_hit_d;
      line_open_q <= line_open_d;
      line_cnt_q  <= line_cnt_d;
      sel_cnt_q   <= sel_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_verdict || emit_count) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a new result only follows a line end or end of stream
  `LSF_ASSERT(a_res_cause, clk_i, rst_ni, $rose(res_valid_q) |-> $past(step_i.newline || step_i.eos), "result without line end or end of stream")
  // end of stream restarts both counters
  `LSF_ASSERT(a_eos_clear, clk_i, rst_ni, step_i.eos |=> (line_cnt_q == '0) && (sel_cnt_q == '0), "counters not cleared at end of stream")
  // selected lines never outnumber lines
  `LSF_ASSERT(a_sel_le_line, clk_i, rst_ni, sel_cnt_q <= line_cnt_q, "selected count above line count")
  // a hit belongs to an open line
  `LSF_ASSERT_ALWAYS(a_hit_open, clk_i, line_hit_q |-> line_open_q, "line hit without open line")

endmodule

// ----- rtl/line_substring_filter_top.sv -----
// ----------------------------------------------------------------------------
// line_substring_filter_top
// fixed string line filter with case folding, invert and saturating counters
// ----------------------------------------------------------------------------
// The block takes one text byte per clock and answers each finished line with
// one verdict (report modes 0 and 1), or gives only the count of selected lines
// at end of stream (mode 2 and up). An item causes at most one result, held in
// a single output register; the input is ready whenever that register is empty
// or being transferred in the same cycle, so the sustained rate is one item per
// cycle while results are taken; each result is registered and shows in the
// cycle after its item. The window compare is combinational. Configure
// only while no result is pending; there is no clearing pass after reset.
module line_substring_filter_top #(
  parameter int unsigned MAX_PATTERN = lsf_pkg::LSF_MAX_PATTERN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsf_pkg::PAT_W-1:0]     cfg_data_i,
  lsf_in_if.sink                        in_i,
  lsf_out_if.source                     out_o
);
  import lsf_pkg::*;

  lsf_cfg_t  cfg;
  lsf_step_t step;
  lsf_res_t  res;
  logic      res_valid;
  logic      hit;
  logic      in_xfer;
  logic      in_ready_w;

  // input transfer decode
  assign in_ready_w  = !res_valid || out_o.ready;
  assign in_i.ready  = in_ready_w;
  assign in_xfer     = in_i.valid && in_ready_w;
  assign step.eos     = in_xfer && in_i.end_of_stream;
  assign step.newline = in_xfer && !in_i.end_of_stream && (in_i.ch == LF_CHAR);
  assign step.push    = in_xfer && !in_i.end_of_stream && (in_i.ch != LF_CHAR);

  lsf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lsf_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .ch_i   (in_i.ch),
    .hit_o  (hit)
  );

  lsf_line_ctl u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .hit_i       (hit),
    .res_ready_i (out_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result channel
  assign out_o.valid       = res_valid;
  assign out_o.kind        = res.kind;
  assign out_o.line_number = res.line_number;
  assign out_o.selected    = res.selected;
  assign out_o.match_count = res.match_count;
  assign out_o.last_of_run = res.last_of_run;

endmodule
